// File: design/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Function codes, status codes, widths and the divider handshake type of the list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam logic [3:0] FN_INS_FRONT = 4'd0;
   localparam logic [3:0] FN_INS_BACK  = 4'd1;
   localparam logic [3:0] FN_DEL_FRONT = 4'd2;
   localparam logic [3:0] FN_DEL_BACK  = 4'd3;
   localparam logic [3:0] FN_DEL_VALUE = 4'd4;
   localparam logic [3:0] FN_SEARCH    = 4'd5;
   localparam logic [3:0] FN_COUNT     = 4'd6;
   localparam logic [3:0] FN_MAX       = 4'd7;
   localparam logic [3:0] FN_MIN       = 4'd8;
   localparam logic [3:0] FN_AVG       = 4'd9;
   localparam logic [3:0] FN_REVERSE   = 4'd10;
   localparam logic [3:0] FN_CLEAR     = 4'd11;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int STATUS_W = 2;
   localparam int RESULT_W = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int MEAN_W   = 40;

   // divider handshake
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// File: design/ble_divider.sv
// ----------------------------------------------------------------------------
// ble_divider
// Restoring divider, one quotient bit a cycle, unsigned.
// ----------------------------------------------------------------------------
module ble_divider
   import ble_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quot,
   output div_ctl_type      ctl
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            r_in = diff[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign quot      = q_ff;
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
endmodule

// File: design/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_list_engine
// Ordered list of signed values in one memory, worked by a small sequencer.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// req     | in        | req_valid/stall   | func, operand_value
// rsp     | out       | rsp_valid/stall   | status, result_value, position,
//         |           |                   | element_count, mean_fixed
// One item at a time. Inserts and removals at the back touch one entry;
// front insert/remove, delete by value and reverse move entries one memory
// access a cycle; search walks up to n reads, max and min walk n reads;
// average adds n reads and a serial division. The memory sets the pace.
// Reset clears the entry count and the sequencer state; the store needs no
// pass. req_stall stays high from acceptance until the result is taken.
module bounded_list_engine
   import ble_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [3:0]                 req_func,
   input  logic signed [31:0]         req_operand_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [RESULT_W-1:0] rsp_result_value,
   output logic [POS_W-1:0]           rsp_position,
   output logic [COUNT_W-1:0]         rsp_element_count,
   output logic signed [MEAN_W-1:0]   rsp_mean_fixed
);
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW   = $clog2(DEPTH + 1);
   localparam int SUMW = DATA_WIDTH + NW + 1;
   localparam int DNUM = 64;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;  // issue read at idx
   localparam logic [3:0] S_RW    = 4'd2;  // data back
   localparam logic [3:0] S_WR    = 4'd3;  // write
   localparam logic [3:0] S_RD2   = 4'd4;  // reverse: second read
   localparam logic [3:0] S_RW2   = 4'd5;
   localparam logic [3:0] S_WR2   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_DIVW  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  we;
   logic [AW-1:0]         waddr, raddr;
   logic [DATA_WIDTH-1:0] wdata;

   logic [3:0]            state_ff, state_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [3:0]            fn_ff, fn_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [NW-1:0]         i_ff, i_in, j_ff, j_in;
   logic [DATA_WIDTH-1:0] hold_ff, hold_in;
   logic [DATA_WIDTH-1:0] best_ff, best_in;
   logic [NW-1:0]         bpos_ff, bpos_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic                  neg_ff, neg_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [RESULT_W-1:0]   rv_ff, rv_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic                  found_ff, found_in;

   logic                  div_start;
   logic [DNUM-1:0]       div_numer, div_quot;
   div_ctl_type           div_ctl;
   logic [SUMW-1:0]       mag;
   logic signed [DATA_WIDTH-1:0] rs;
   logic signed [DATA_WIDTH-1:0] bs;
   logic [DNUM-1:0]       qmag;

   ble_divider #(.NUM_W(DNUM), .DEN_W(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (n_ff),
      .quot  (div_quot),
      .ctl   (div_ctl)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rs = $signed(rdata_ff);
   assign bs = $signed(best_ff);
   assign mag = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
   assign div_numer = DNUM'({mag, 8'h00});
   assign qmag = div_quot;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      fn_in = fn_ff;
      x_in = x_ff;
      i_in = i_ff;
      j_in = j_ff;
      hold_in = hold_ff;
      best_in = best_ff;
      bpos_in = bpos_ff;
      sum_in = sum_ff;
      neg_in = neg_ff;
      st_in = st_ff;
      rv_in = rv_ff;
      pos_in = pos_ff;
      mean_in = mean_ff;
      found_in = found_ff;
      we = 1'b0;
      waddr = i_ff[AW-1:0];
      raddr = i_ff[AW-1:0];
      wdata = x_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fn_in = req_func;
               x_in = req_operand_value[DATA_WIDTH-1:0];
               st_in = ST_OK;
               rv_in = '0;
               pos_in = '0;
               mean_in = '0;
               found_in = 1'b0;
               sum_in = '0;
               i_in = '0;
               j_in = '0;
               state_in = S_RESP;
               case (req_func)
                  FN_INS_FRONT: begin
                     if (n_ff == NW'(DEPTH)) st_in = ST_FULL;
                     else if (n_ff == '0) state_in = S_WR;
                     else begin
                        // shift up from the back
                        i_in = n_ff - 1'b1;
                        state_in = S_RD;
                     end
                  end
                  FN_INS_BACK: begin
                     if (n_ff == NW'(DEPTH)) st_in = ST_FULL;
                     else begin
                        i_in = n_ff;
                        state_in = S_WR;
                     end
                  end
                  FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_VALUE, FN_MAX, FN_MIN,
                  FN_AVG: begin
                     if (n_ff == '0) st_in = ST_EMPTY;
                     else begin
                        i_in = (req_func == FN_DEL_BACK) ? n_ff - 1'b1 : '0;
                        state_in = S_RD;
                     end
                  end
                  FN_SEARCH: begin
                     st_in = ST_NOTFOUND;
                     if (n_ff != '0) state_in = S_RD;
                  end
                  FN_REVERSE: begin
                     if (n_ff > NW'(1)) begin
                        j_in = n_ff - 1'b1;
                        state_in = S_RD;
                     end
                  end
                  FN_CLEAR: n_in = '0;
                  default: ;
               endcase
            end
         end
         S_RD: state_in = S_RW;
         S_RW: begin
            case (fn_ff)
               FN_INS_FRONT: begin
                  hold_in = rdata_ff;
                  state_in = S_WR;
               end
               FN_DEL_BACK: begin
                  rv_in = RESULT_W'(rs);
                  n_in = n_ff - 1'b1;
                  state_in = S_RESP;
               end
               FN_DEL_FRONT: begin
                  if (i_ff == '0) rv_in = RESULT_W'(rs);
                  hold_in = rdata_ff;
                  if (i_ff == '0) begin
                     i_in = NW'(1);
                     if (n_ff == NW'(1)) begin
                        n_in = '0;
                        state_in = S_RESP;
                     end else state_in = S_RD;
                  end else state_in = S_WR;
               end
               FN_DEL_VALUE: begin
                  hold_in = rdata_ff;
                  if (rdata_ff != x_ff) state_in = S_WR;
                  else begin
                     found_in = 1'b1;
                     if (i_ff == n_ff - 1'b1) begin
                        n_in = j_ff;
                        state_in = S_RESP;
                     end else begin
                        i_in = i_ff + 1'b1;
                        state_in = S_RD;
                     end
                  end
               end
               FN_SEARCH: begin
                  if (rdata_ff == x_ff) begin
                     st_in = ST_OK;
                     pos_in = POS_W'(i_ff);
                     state_in = S_RESP;
                  end else if (i_ff == n_ff - 1'b1) state_in = S_RESP;
                  else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               FN_MAX, FN_MIN: begin
                  if (i_ff == '0 || (fn_ff == FN_MAX ? rs > bs : rs < bs)) begin
                     best_in = rdata_ff;
                     bpos_in = i_ff;
                  end
                  if (i_ff == n_ff - 1'b1) state_in = S_RESP;
                  else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               FN_AVG: begin
                  sum_in = sum_ff + SUMW'(rs);
                  if (i_ff == n_ff - 1'b1) state_in = S_DIV;
                  else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               default: begin  // reverse: first entry fetched
                  hold_in = rdata_ff;
                  state_in = S_RD2;
               end
            endcase
         end
         S_WR: begin
            we = 1'b1;
            case (fn_ff)
               FN_INS_FRONT: begin
                  // move entry i up, or drop the new item into slot 0
                  if (j_ff == NW'(1)) begin
                     waddr = '0;
                     wdata = x_ff;
                     n_in = n_ff + 1'b1;
                     state_in = S_RESP;
                  end else if (n_ff == '0) begin
                     waddr = '0;
                     wdata = x_ff;
                     n_in = NW'(1);
                     state_in = S_RESP;
                  end else begin
                     waddr = AW'(i_ff + 1'b1);
                     wdata = hold_ff;
                     if (i_ff == '0) j_in = NW'(1);
                     else i_in = i_ff - 1'b1;
                     state_in = (i_ff == '0) ? S_WR : S_RD;
                  end
               end
               FN_INS_BACK: begin
                  n_in = n_ff + 1'b1;
                  state_in = S_RESP;
               end
               FN_DEL_FRONT: begin
                  waddr = AW'(i_ff - 1'b1);
                  wdata = hold_ff;
                  if (i_ff == n_ff - 1'b1) begin
                     n_in = n_ff - 1'b1;
                     state_in = S_RESP;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               FN_DEL_VALUE: begin
                  waddr = j_ff[AW-1:0];
                  wdata = hold_ff;
                  j_in = j_ff + 1'b1;
                  if (i_ff == n_ff - 1'b1) begin
                     n_in = j_ff + 1'b1;
                     state_in = S_RESP;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
               default: begin  // reverse: front slot takes back entry
                  wdata = rdata_ff;
                  state_in = S_WR2;
               end
            endcase
         end
         S_RD2: begin
            raddr = j_ff[AW-1:0];
            state_in = S_RW2;
         end
         S_RW2: begin
            raddr = j_ff[AW-1:0];
            state_in = S_WR;
         end
         S_WR2: begin
            we = 1'b1;
            waddr = j_ff[AW-1:0];
            wdata = hold_ff;
            i_in = i_ff + 1'b1;
            j_in = j_ff - 1'b1;
            state_in = (i_ff + 1'b1 < j_ff - 1'b1) ? S_RD : S_RESP;
         end
         S_DIV: begin
            div_start = 1'b1;
            neg_in = sum_ff[SUMW-1];
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_ctl.done) begin
               mean_in = neg_ff ? -MEAN_W'(qmag) : MEAN_W'(qmag);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_RW && (fn_ff == FN_MAX || fn_ff == FN_MIN)
          && i_ff == n_ff - 1'b1) begin
         if (i_ff == '0 || (fn_ff == FN_MAX ? rs > bs : rs < bs)) begin
            rv_in = RESULT_W'(rs);
            pos_in = POS_W'(i_ff);
         end else begin
            rv_in = RESULT_W'(bs);
            pos_in = POS_W'(bpos_ff);
         end
      end
   end

   // delete-by-value reports not found when nothing matched
   logic [STATUS_W-1:0] st_out;
   assign st_out = (fn_ff == FN_DEL_VALUE && st_ff == ST_OK && !found_ff)
                   ? ST_NOTFOUND : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
      end
      fn_ff <= fn_in;
      x_ff <= x_in;
      i_ff <= i_in;
      j_ff <= j_in;
      hold_ff <= hold_in;
      best_ff <= best_in;
      bpos_ff <= bpos_in;
      sum_ff <= sum_in;
      neg_ff <= neg_in;
      st_ff <= st_in;
      rv_ff <= rv_in;
      pos_ff <= pos_in;
      mean_ff <= mean_in;
      found_ff <= found_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = st_out;
   assign rsp_result_value = rv_ff;
   assign rsp_position = pos_ff;
   assign rsp_element_count = COUNT_W'(n_ff);
   assign rsp_mean_fixed = mean_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(DEPTH)) else $error("entry count beyond depth");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("result shown while idle");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.busy |-> state_ff == S_DIVW) else $error("divider busy off sequence");
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> state_ff == S_IDLE) else $error("result not retired");
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives list requests with random gaps and result back-pressure, keeps its
// own copy of the list and checks every result field against it.
// ----------------------------------------------------------------------------
module tb
   import ble_pkg::*;
();

   localparam int LIST_DEPTH = 256;

   // function codes with no operation
   localparam logic [3:0] FN_SPARE_FIRST = 4'd12;
   localparam logic [3:0] FN_SPARE_LAST  = 4'd15;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] result_value;
      logic [7:0]         position;
      logic [8:0]         element_count;
      logic signed [39:0] mean_fixed;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_func = '0;
   logic signed [31:0] req_operand_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_result_value;
   logic [7:0] rsp_position;
   logic [8:0] rsp_element_count;
   logic signed [39:0] rsp_mean_fixed;

   logic signed [31:0] shadow_list[LIST_DEPTH];
   int                 shadow_total = 0;
   list_result_type    expected_results[$];
   int                 error_count = 0;
   int                 results_seen = 0;
   int                 items_sent = 0;
   int                 hold_off_cycles = 0;

   bounded_list_engine dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic list_result_type apply_request(logic [3:0] fn, logic signed [31:0] x);
      list_result_type r;
      int j;
      int n;
      logic signed [31:0] t;
      logic signed [63:0] sum;
      logic [63:0] mag;
      logic [63:0] quo;
      r = '{default: '0};
      n = shadow_total;
      case (fn)
         FN_INS_FRONT, FN_INS_BACK: begin
            if (n >= LIST_DEPTH) r.status = ST_FULL;
            else if (fn == FN_INS_BACK) begin
               shadow_list[n] = x;
               n++;
            end else begin
               for (int i = n; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = x;
               n++;
            end
         end
         FN_DEL_FRONT, FN_DEL_BACK: begin
            if (n == 0) r.status = ST_EMPTY;
            else if (fn == FN_DEL_BACK) begin
               r.result_value = shadow_list[n-1];
               n--;
            end else begin
               r.result_value = shadow_list[0];
               for (int i = 0; i < n - 1; i++) shadow_list[i] = shadow_list[i+1];
               n--;
            end
         end
         FN_DEL_VALUE: begin
            if (n == 0) r.status = ST_EMPTY;
            else begin
               j = 0;
               for (int i = 0; i < n; i++)
                  if (shadow_list[i] != x) begin
                     shadow_list[j] = shadow_list[i];
                     j++;
                  end
               if (j == n) r.status = ST_NOTFOUND;
               n = j;
            end
         end
         FN_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < n; i++)
               if (shadow_list[i] == x) begin
                  r.status = ST_OK;
                  r.position = 8'(i);
                  break;
               end
         end
         FN_MAX, FN_MIN: begin
            if (n == 0) r.status = ST_EMPTY;
            else begin
               r.result_value = shadow_list[0];
               for (int i = 1; i < n; i++)
                  if ((fn == FN_MAX) ? (shadow_list[i] > r.result_value)
                                     : (shadow_list[i] < r.result_value)) begin
                     r.result_value = shadow_list[i];
                     r.position = 8'(i);
                  end
            end
         end
         FN_AVG: begin
            if (n == 0) r.status = ST_EMPTY;
            else begin
               sum = 0;
               for (int i = 0; i < n; i++) sum += 64'(shadow_list[i]);
               mag = (sum < 0) ? 64'(-sum) : 64'(sum);
               quo = (mag << 8) / 64'(n);
               r.mean_fixed = (sum < 0) ? 40'(-quo) : 40'(quo);
            end
         end
         FN_REVERSE: begin
            for (int i = 0; i < n / 2; i++) begin
               t = shadow_list[i];
               shadow_list[i] = shadow_list[n-1-i];
               shadow_list[n-1-i] = t;
            end
         end
         FN_CLEAR: n = 0;
         default: ;
      endcase
      shadow_total = n;
      r.element_count = 9'(n);
      return r;
   endfunction

   // accept-side checker: compare each result with the oldest expectation
   always @(posedge clock) begin
      list_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_result_value !== e.result_value) begin
               $error("result_value exp %0d got %0d", e.result_value, rsp_result_value);
               error_count++;
            end
            if (rsp_position !== e.position) begin
               $error("position exp %0d got %0d", e.position, rsp_position);
               error_count++;
            end
            if (rsp_element_count !== e.element_count) begin
               $error("element_count exp %0d got %0d", e.element_count, rsp_element_count);
               error_count++;
            end
            if (rsp_mean_fixed !== e.mean_fixed) begin
               $error("mean_fixed exp %0d got %0d", e.mean_fixed, rsp_mean_fixed);
               error_count++;
            end
         end
      end
   end

   // result back-pressure; a long hold-off wins over random stalls
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) < 7) rsp_stall <= 1'b0;
      else rsp_stall <= 1'b1;
   end

   function automatic int gap_cycles();
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      return g;
   endfunction

   // with no gap, keep valid up and offer the next item straight away
   task automatic send_item(logic [3:0] fn, logic signed [31:0] x);
      int g;
      req_valid <= 1'b1;
      req_func <= fn;
      req_operand_value <= x;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(apply_request(fn, x));
      items_sent++;
      g = gap_cycles();
      if (g > 0) begin
         req_valid <= 1'b0;
         req_func <= 4'($urandom);
         req_operand_value <= $urandom;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return shadow_total ? shadow_list[$urandom_range(0, shadow_total - 1)] : 0;
         3: return $urandom;
         default: return $signed(32'($urandom_range(0, 7)) - 32'd3);
      endcase
   endfunction

   task automatic test_directed();
      send_item(FN_DEL_FRONT, 0);
      send_item(FN_DEL_BACK, 0);
      send_item(FN_DEL_VALUE, 5);
      send_item(FN_SEARCH, 5);
      send_item(FN_MAX, 0);
      send_item(FN_MIN, 0);
      send_item(FN_AVG, 0);
      send_item(FN_REVERSE, 0);
      send_item(FN_CLEAR, 0);
      send_item(FN_INS_BACK, 7);
      send_item(FN_DEL_VALUE, 8);
      send_item(FN_DEL_VALUE, 7);
      send_item(FN_INS_BACK, 32'sh7fffffff);
      send_item(FN_INS_FRONT, 32'sh80000000);
      send_item(FN_INS_BACK, 32'sh7fffffff);
      send_item(FN_MAX, 0);
      send_item(FN_MIN, 0);
      send_item(FN_AVG, 0);
      send_item(FN_SEARCH, 32'sh7fffffff);
      send_item(FN_REVERSE, 0);
      send_item(FN_COUNT, 0);
      send_item(FN_SPARE_FIRST, 1);
      send_item(FN_SPARE_LAST, -1);
      send_item(FN_DEL_FRONT, 0);
      send_item(FN_DEL_VALUE, 32'sh7fffffff);
   endtask

   // fill to the limit, overflow at both ends, then max, average, reverse and clear
   task automatic test_full_list();
      while (shadow_total < LIST_DEPTH) send_item(FN_INS_BACK, pick_value());
      send_item(FN_INS_FRONT, 1);
      send_item(FN_INS_BACK, 1);
      send_item(FN_MAX, 0);
      send_item(FN_AVG, 0);
      send_item(FN_REVERSE, 0);
      send_item(FN_CLEAR, 0);
   endtask

   task automatic test_back_pressure();
      drain();
      hold_off_cycles <= 400;
      repeat (6) send_item(FN_INS_BACK, pick_value());
   endtask

   task automatic test_random(int count);
      logic [3:0] fn;
      repeat (count) begin
         if ($urandom_range(0, 39) == 0)
            fn = 4'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
         else if (shadow_total < 4 || $urandom_range(0, 2) == 0)
            fn = $urandom_range(0, 1) ? FN_INS_BACK : FN_INS_FRONT;
         else if ($urandom_range(0, 60) == 0) fn = FN_CLEAR;
         else fn = 4'($urandom_range(FN_INS_FRONT, FN_REVERSE));
         send_item(fn, pick_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_pressure();
      test_random(150);
      test_full_list();
      test_random(150);
      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d list requests, checked %0d results,", items_sent, results_seen);
      $display("including a full list, empty-list cases and a long result hold-off.");
      if (error_count == 0 && expected_results.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
